// ===== src/nrpe_pkg.sv =====
// Package with the shared types, constants and decode functions of the RMC position extractor.
package nrpe_pkg;

  localparam int unsigned PAYLOAD_LEN = 63;
  localparam int unsigned HEADER_LEN  = 6;
  localparam int unsigned STORE_N     = 12;
  localparam int unsigned GROUP_LEN   = 11;
  localparam int unsigned SEQ_LEN     = 2 * GROUP_LEN;

  localparam logic [7:0] START_MARK = 8'h24;
  localparam logic [7:0] CURSOR_LAT = 8'h84;
  localparam logic [7:0] CURSOR_LON = 8'hC4;
  localparam logic [7:0] DEGREE_SGN = 8'd223;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_NORTH = 8'h4E;
  localparam logic [7:0] CHAR_EAST  = 8'h45;

  localparam logic [5:0] LAST_COUNT = 6'(PAYLOAD_LEN - 1);
  localparam logic [5:0] HEAD_LAST  = 6'(HEADER_LEN - 1);
  localparam logic [4:0] SEQ_LAST   = 5'(SEQ_LEN - 1);
  localparam logic [4:0] GROUP_N    = 5'(GROUP_LEN);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HEAD = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  typedef struct packed {
    logic [STORE_N-1:0][7:0] field;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } keep_t;

  typedef struct packed {
    logic [7:0] data;
    logic       cmd;
    logic       last;
  } item_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4D;
      3'd4:    c = 8'h43;
      3'd5:    c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic keep_t keep_slot(input logic [5:0] cnt);
    keep_t k;
    k.hit = 1'b1;
    unique case (cnt)
      6'd12:   k.slot = 4'd0;
      6'd13:   k.slot = 4'd1;
      6'd14:   k.slot = 4'd2;
      6'd15:   k.slot = 4'd3;
      6'd17:   k.slot = 4'd4;
      6'd18:   k.slot = 4'd5;
      6'd26:   k.slot = 4'd6;
      6'd27:   k.slot = 4'd7;
      6'd28:   k.slot = 4'd8;
      6'd29:   k.slot = 4'd9;
      6'd31:   k.slot = 4'd10;
      6'd32:   k.slot = 4'd11;
      default: begin
        k.hit  = 1'b0;
        k.slot = 4'd0;
      end
    endcase
    return k;
  endfunction

  function automatic item_t seq_item(input logic [4:0] idx, input job_t job);
    item_t      it;
    logic       grp;
    logic [4:0] k;
    logic [3:0] base;
    grp  = (idx >= GROUP_N);
    k    = grp ? (idx - GROUP_N) : idx;
    base = grp ? 4'd6 : 4'd0;
    it.cmd  = 1'b0;
    it.last = (idx == SEQ_LAST);
    unique case (k)
      5'd0: begin
        it.data = grp ? CURSOR_LON : CURSOR_LAT;
        it.cmd  = 1'b1;
      end
      5'd1:    it.data = job.field[base];
      5'd2:    it.data = job.field[base + 4'd1];
      5'd3:    it.data = CHAR_DOT;
      5'd4:    it.data = job.field[base + 4'd2];
      5'd5:    it.data = job.field[base + 4'd3];
      5'd6:    it.data = job.field[base + 4'd4];
      5'd7:    it.data = job.field[base + 4'd5];
      5'd8:    it.data = DEGREE_SGN;
      5'd9:    it.data = CHAR_SPACE;
      5'd10:   it.data = grp ? CHAR_EAST : CHAR_NORTH;
      default: it.data = CHAR_SPACE;
    endcase
    return it;
  endfunction

endpackage

// ===== src/nrpe_front.sv =====
// Sentence parser that matches the header, latches the position bytes and posts display jobs.
module nrpe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [7:0]     byte_i,
  input  logic           full_i,
  output logic           ready_o,
  output logic           push_o,
  output nrpe_pkg::job_t job_o
);
  import nrpe_pkg::*;

  phase_e     phase_q, phase_d;
  logic [5:0] count_q, count_d;
  logic       hdr_ok_q, hdr_ok_d;
  job_t       store_q, store_d;
  keep_t      keep;
  logic       take;
  logic       hdr_ok_now;

  assign ready_o = !full_i;
  assign take    = valid_i && ready_o;
  assign keep    = keep_slot(count_q);
  assign hdr_ok_now = hdr_ok_q && (byte_i == hdr_char(count_q[2:0]));

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    hdr_ok_d = hdr_ok_q;
    store_d  = store_q;
    push_o   = 1'b0;
    if (take) begin
      unique case (phase_q)
        PH_HEAD: begin
          hdr_ok_d = hdr_ok_now;
          count_d  = count_q + 6'd1;
          if (count_q >= HEAD_LAST) begin
            count_d = 6'd0;
            phase_d = hdr_ok_now ? PH_BODY : PH_IDLE;
          end
        end
        PH_BODY: begin
          if (keep.hit) begin
            store_d.field[keep.slot] = byte_i;
          end
          if (count_q >= LAST_COUNT) begin
            push_o  = 1'b1;
            count_d = 6'd0;
            phase_d = PH_IDLE;
          end else begin
            count_d = count_q + 6'd1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (byte_i == START_MARK) begin
            phase_d  = PH_HEAD;
            count_d  = 6'd0;
            hdr_ok_d = 1'b1;
          end
        end
      endcase
    end
  end

  assign job_o = store_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      count_q  <= 6'd0;
      hdr_ok_q <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      hdr_ok_q <= hdr_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

endmodule

// ===== src/nrpe_fifo.sv =====
// Two-entry queue of display jobs between the parser and the display sequencer.
module nrpe_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nrpe_pkg::job_t job_i,
  input  logic           pop_i,
  output nrpe_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);
  import nrpe_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== src/nrpe_back.sv =====
// Display sequencer that turns one job into the 22-item cursor and character run.
module nrpe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  nrpe_pkg::job_t job_i,
  output logic           pop_o,
  input  logic           ready_i,
  output logic           valid_o,
  output logic [7:0]     data_o,
  output logic           cmd_o,
  output logic           last_o
);
  import nrpe_pkg::*;

  job_t       job_q;
  logic       busy_q;
  logic [4:0] idx_q;
  logic       out_vld_q;
  item_t      out_q;
  item_t      cur;
  logic       can_load;

  assign can_load = !out_vld_q || ready_i;
  assign pop_o    = !busy_q && !empty_i;
  assign cur      = seq_item(idx_q, job_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= 5'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (busy_q && can_load) begin
        out_vld_q <= 1'b1;
      end else if (ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 5'd0;
      end else if (busy_q && can_load) begin
        idx_q <= idx_q + 5'd1;
        if (idx_q == SEQ_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (busy_q && can_load) begin
      out_q <= cur;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q.data;
  assign cmd_o   = out_q.cmd;
  assign last_o  = out_q.last;

endmodule

// ===== src/nmea_rmc_position_extractor_top.sv =====
// Top level of the RMC position extractor: parser, job queue and display sequencer.
//
// Usage: received serial bytes enter on the s_axis channel, one byte per request.
// Outside a sentence every byte but the start mark is dropped. After the start mark
// six header bytes are compared with the RMC header; on a match the next 63 payload
// bytes are taken and the latitude and longitude digits are latched from them.
// The last payload byte posts one job to a two-entry queue. The sequencer then
// sends 22 requests on the m_axis channel: a cursor command (tuser high), the
// latitude text, a second cursor command and the longitude text; tlast marks the
// final request. With the sequencer idle, a job passes through the queue, the sequencer's
// job register and its output register before its first request is offered; the sequencer
// then sends one request per cycle while the receiver is ready, fetching jobs only when idle.
// Input bytes are taken every cycle; s_axis_tready drops only while the queue
// holds two jobs, which happens only when the receiver stalls for long.
// A stalled receiver holds the current request in the output register.
// Reset clears the parser to idle, empties the queue and drops m_axis_tvalid.
module nmea_rmc_position_extractor_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] lcd_byte
  output logic       m_axis_tuser,   // [0] is_command
  output logic       m_axis_tlast    // last_of_run
);
  import nrpe_pkg::*;

  logic push, pop, full, empty;
  job_t push_job, head_job;

  nrpe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .byte_i  (s_axis_tdata),
    .full_i  (full),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .job_o   (push_job)
  );

  nrpe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  nrpe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (head_job),
    .pop_o   (pop),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata),
    .cmd_o   (m_axis_tuser),
    .last_o  (m_axis_tlast)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("job posted while the queue is full");

  a_cmd_is_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata == CURSOR_LAT || m_axis_tdata == CURSOR_LON))
    else $error("command request is not a cursor position");

  a_last_is_east: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tuser && m_axis_tdata == CHAR_EAST))
    else $error("final request of a run is not the east mark");

  a_cursor_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) ##1 m_axis_tvalid |->
      (m_axis_tuser && m_axis_tdata == CURSOR_LAT))
    else $error("new run does not open with the latitude cursor");

endmodule
